// File: design/lramt_pkg.sv
// Shared types, constants and helpers for the lazy range-add / range-min tree.
package lramt_pkg;

   localparam int MAX_ELEMENTS = 1024;
   localparam int TREE_NODES   = 4096;
   localparam int DATA_W       = 48;
   localparam int IDX_W        = 10;
   localparam int NODE_W       = 12;
   localparam int N_W          = 11;
   // Root at level 0 down to leaves at level 10: at most 10 saved parents.
   localparam int STACK_DEPTH  = 11;
   localparam int SP_W         = 4;

   localparam logic [N_W-1:0]    N_RESET      = 11'd1024;
   localparam logic [DATA_W-1:0] EMPTY_MARK   = 48'd10000000;
   localparam logic [N_W-1:0]    N_MAX        = 11'd1024;
   localparam logic [IDX_W-1:0]  LAST_INDEX   = 10'd1023;
   localparam logic [NODE_W-1:0] ROOT_NODE    = 12'd1;

   typedef enum logic [1:0] {
      MODE_LOAD  = 2'd0,
      MODE_BUILD = 2'd1,
      MODE_ADD   = 2'd2,
      MODE_QUERY = 2'd3
   } mode_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_ENTER,
      S_LEAF_RD,
      S_EXACT_RD,
      S_PD_PARENT,
      S_PD_LEFT,
      S_PD_RIGHT,
      S_PD_CLEAR,
      S_CHILD,
      S_RC_LEFT,
      S_RC_RIGHT,
      S_RET,
      S_RESP
   } state_type;

   typedef enum logic [1:0] {
      RD_SELF,
      RD_LEFT,
      RD_RIGHT
   } rd_sel_type;

   typedef enum logic [2:0] {
      WR_NONE,
      WR_PD_LEFT,
      WR_PD_RIGHT,
      WR_PD_CLEAR,
      WR_EXACT_ADD,
      WR_LEAF,
      WR_RECOMBINE
   } wr_sel_type;

   typedef enum logic [2:0] {
      FR_NONE,
      FR_ADV,
      FR_PUSH_LEFT,
      FR_PUSH_RIGHT,
      FR_POP
   } frame_op_type;

   typedef enum logic [1:0] {
      RET_NONE,
      RET_EXACT,
      RET_ACC
   } ret_sel_type;

   typedef struct packed {
      logic [DATA_W-1:0] val;
      logic [DATA_W-1:0] tag;
   } node_word_type;

   typedef struct packed {
      logic [NODE_W-1:0] v;
      logic [IDX_W-1:0]  tl;
      logic [IDX_W-1:0]  tr;
      logic [IDX_W-1:0]  l;
      logic [IDX_W-1:0]  r;
      logic [1:0]        phase;
      logic [DATA_W-1:0] acc;
      logic              acc_valid;
   } frame_type;

   typedef struct packed {
      logic         take;
      rd_sel_type   rd_sel;
      wr_sel_type   wr_sel;
      frame_op_type frame_op;
      ret_sel_type  ret_sel;
      logic         pd_latch;
      logic         rc_latch;
      logic         rsp_load;
   } cmd_type;

   typedef struct packed {
      mode_type   op;
      logic       leaf;
      logic       exact;
      logic       empty;
      logic       has_left;
      logic       has_right;
      logic [1:0] phase;
      logic       sp_zero;
      logic       req_empty;
      logic       rsp_free;
   } status_type;

   function automatic logic [DATA_W-1:0] min48(input logic [DATA_W-1:0] a,
                                               input logic [DATA_W-1:0] b);
      return ($signed(a) <= $signed(b)) ? a : b;
   endfunction

endpackage

// File: design/lramt_ram.sv
// Generic single-write, single-read RAM with registered read data.
module lramt_ram #(
   parameter int WIDTH = 48,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// File: design/lramt_dp.sv
// Datapath: node and element memories, walk stack, push-down and result registers.
module lramt_dp import lramt_pkg::*; (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     csr_write,
   input  logic [N_W-1:0]           csr_n_used,
   input  logic [1:0]               req_mode,
   input  logic [IDX_W-1:0]         req_index_low,
   input  logic [IDX_W-1:0]         req_index_high,
   input  logic signed [DATA_W-1:0] req_value,
   input  logic                     rsp_stall,
   input  cmd_type                  cmd,
   output status_type               status,
   output logic                     rsp_valid,
   output logic signed [DATA_W-1:0] rsp_min_value,
   output logic                     rsp_empty_range
);

   logic [N_W-1:0]    n_used_ff;
   mode_type          op_ff;
   logic [DATA_W-1:0] val_ff;
   logic              empty_ff;
   logic [DATA_W-1:0] ret_ff;
   logic [DATA_W-1:0] pd_add_ff;
   logic [DATA_W-1:0] pd_val_ff;
   logic [DATA_W-1:0] rc_left_ff;
   frame_type         cur_ff;
   frame_type         stack_ff [STACK_DEPTH];
   logic [SP_W-1:0]   sp_ff;
   logic              rsp_valid_ff;
   logic [DATA_W-1:0] rsp_min_ff;
   logic              rsp_empty_ff;

   logic [IDX_W-1:0]      last_idx;
   logic [IDX_W-1:0]      clip_high;
   logic [IDX_W:0]        tsum;
   logic [IDX_W-1:0]      tm;
   logic [IDX_W-1:0]      tm1;
   logic [NODE_W-1:0]     left_v;
   logic [NODE_W-1:0]     right_v;
   frame_type             left_fr;
   frame_type             right_fr;
   frame_type             saved_fr;
   frame_type             parent_fr;
   logic [SP_W-1:0]       sp_prev;

   logic                  node_we;
   logic [NODE_W-1:0]     node_waddr;
   node_word_type         node_wword;
   logic [NODE_W-1:0]     node_raddr;
   logic [2*DATA_W-1:0]   node_rdata;
   node_word_type         node_rword;
   logic                  elem_we;
   logic [DATA_W-1:0]     elem_rdata;

   // Effective element count minus one: zero counts as one, cap at the store size.
   always_comb begin
      priority if (n_used_ff == '0) begin
         last_idx = '0;
      end else if (n_used_ff > N_MAX) begin
         last_idx = LAST_INDEX;
      end else begin
         last_idx = IDX_W'(n_used_ff - 1'b1);
      end
   end

   assign clip_high = (req_index_high > last_idx) ? last_idx : req_index_high;

   assign tsum    = {1'b0, cur_ff.tl} + {1'b0, cur_ff.tr};
   assign tm      = tsum[IDX_W:1];
   assign tm1     = tm + 1'b1;
   assign left_v  = {cur_ff.v[NODE_W-2:0], 1'b0};
   assign right_v = {cur_ff.v[NODE_W-2:0], 1'b1};
   assign sp_prev = sp_ff - 1'b1;

   always_comb begin
      left_fr           = '0;
      left_fr.v         = left_v;
      left_fr.tl        = cur_ff.tl;
      left_fr.tr        = tm;
      left_fr.l         = cur_ff.l;
      left_fr.r         = (cur_ff.r < tm) ? cur_ff.r : tm;
      right_fr          = '0;
      right_fr.v        = right_v;
      right_fr.tl       = tm1;
      right_fr.tr       = cur_ff.tr;
      right_fr.l        = (cur_ff.l > tm1) ? cur_ff.l : tm1;
      right_fr.r        = cur_ff.r;
      saved_fr          = cur_ff;
      saved_fr.phase    = cur_ff.phase + 1'b1;
      parent_fr         = stack_ff[sp_prev];
      parent_fr.acc     = parent_fr.acc_valid ? min48(parent_fr.acc, ret_ff) : ret_ff;
      parent_fr.acc_valid = 1'b1;
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         n_used_ff    <= N_RESET;
         sp_ff        <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_write) begin
            n_used_ff <= csr_n_used;
         end
         unique case (cmd.frame_op)
            FR_PUSH_LEFT, FR_PUSH_RIGHT: sp_ff <= sp_ff + 1'b1;
            FR_POP:                      sp_ff <= sp_prev;
            default:                     sp_ff <= cmd.take ? '0 : sp_ff;
         endcase
         if (cmd.rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      if (cmd.take) begin
         op_ff     <= mode_type'(req_mode);
         val_ff    <= req_value;
         empty_ff  <= req_index_low > clip_high;
         cur_ff    <= '{v: ROOT_NODE, tl: '0, tr: last_idx, l: req_index_low,
                        r: clip_high, phase: '0, acc: '0, acc_valid: 1'b0};
      end else begin
         unique case (cmd.frame_op)
            FR_ADV:        cur_ff.phase <= cur_ff.phase + 1'b1;
            FR_PUSH_LEFT:  cur_ff <= left_fr;
            FR_PUSH_RIGHT: cur_ff <= right_fr;
            FR_POP:        cur_ff <= parent_fr;
            default:       cur_ff <= cur_ff;
         endcase
      end
      if (cmd.frame_op == FR_PUSH_LEFT || cmd.frame_op == FR_PUSH_RIGHT) begin
         stack_ff[sp_ff] <= saved_fr;
      end
      unique case (cmd.ret_sel)
         RET_EXACT: ret_ff <= node_rword.val;
         RET_ACC:   ret_ff <= cur_ff.acc;
         default:   ret_ff <= ret_ff;
      endcase
      if (cmd.pd_latch) begin
         pd_add_ff <= node_rword.tag;
         pd_val_ff <= node_rword.val;
      end
      if (cmd.rc_latch) begin
         rc_left_ff <= node_rword.val;
      end
      if (cmd.rsp_load) begin
         rsp_min_ff   <= empty_ff ? EMPTY_MARK : ret_ff;
         rsp_empty_ff <= empty_ff;
      end
   end

   // Node memory access.
   assign node_rword = node_word_type'(node_rdata);

   always_comb begin
      unique case (cmd.rd_sel)
         RD_LEFT:  node_raddr = left_v;
         RD_RIGHT: node_raddr = right_v;
         default:  node_raddr = cur_ff.v;
      endcase
   end

   always_comb begin
      node_we     = 1'b1;
      node_waddr  = cur_ff.v;
      node_wword  = '0;
      unique case (cmd.wr_sel)
         WR_PD_LEFT: begin
            node_waddr      = left_v;
            node_wword.val  = node_rword.val + pd_add_ff;
            node_wword.tag  = node_rword.tag + pd_add_ff;
         end
         WR_PD_RIGHT: begin
            node_waddr      = right_v;
            node_wword.val  = node_rword.val + pd_add_ff;
            node_wword.tag  = node_rword.tag + pd_add_ff;
         end
         WR_PD_CLEAR: begin
            node_wword.val  = pd_val_ff;
         end
         WR_EXACT_ADD: begin
            node_wword.val  = node_rword.val + val_ff;
            node_wword.tag  = node_rword.tag + val_ff;
         end
         WR_LEAF: begin
            node_wword.val  = elem_rdata;
         end
         WR_RECOMBINE: begin
            node_wword.val  = min48(rc_left_ff, node_rword.val);
         end
         default: begin
            node_we = 1'b0;
         end
      endcase
   end

   lramt_ram #(.WIDTH(2*DATA_W), .DEPTH(TREE_NODES)) u_node_ram (
      .clock   (clock),
      .wr_en   (node_we),
      .wr_addr (node_waddr),
      .wr_data (node_wword),
      .rd_addr (node_raddr),
      .rd_data (node_rdata)
   );

   assign elem_we = cmd.take && (mode_type'(req_mode) == MODE_LOAD);

   lramt_ram #(.WIDTH(DATA_W), .DEPTH(MAX_ELEMENTS)) u_elem_ram (
      .clock   (clock),
      .wr_en   (elem_we),
      .wr_addr (req_index_low),
      .wr_data (req_value),
      .rd_addr (cur_ff.tl),
      .rd_data (elem_rdata)
   );

   always_comb begin
      status.op        = op_ff;
      status.leaf      = cur_ff.tl == cur_ff.tr;
      status.exact     = (cur_ff.l == cur_ff.tl) && (cur_ff.r == cur_ff.tr);
      status.empty     = cur_ff.l > cur_ff.r;
      status.has_left  = cur_ff.l <= tm;
      status.has_right = cur_ff.r > tm;
      status.phase     = cur_ff.phase;
      status.sp_zero   = sp_ff == '0;
      status.req_empty = req_index_low > clip_high;
      status.rsp_free  = !rsp_valid_ff || !rsp_stall;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_min_value   = rsp_min_ff;
   assign rsp_empty_range = rsp_empty_ff;

endmodule

// File: design/lramt_ctrl.sv
// Controller: sequences the tree walk one memory access at a time.
module lramt_ctrl import lramt_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   input  logic [1:0] req_mode,
   input  status_type status,
   output logic       req_stall,
   output cmd_type    cmd
);

   state_type state_ff;
   state_type state_in;
   logic      is_query;

   assign is_query = status.op == MODE_QUERY;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               priority if (mode_type'(req_mode) == MODE_LOAD) begin
                  state_in = S_IDLE;
               end else if (mode_type'(req_mode) == MODE_QUERY && status.req_empty) begin
                  state_in = S_RESP;
               end else begin
                  state_in = S_ENTER;
               end
            end
         end
         S_ENTER: begin
            priority if (status.op == MODE_BUILD) begin
               state_in = status.leaf ? S_LEAF_RD : S_CHILD;
            end else if (status.op == MODE_ADD && status.empty) begin
               state_in = S_RET;
            end else if (status.exact) begin
               state_in = S_EXACT_RD;
            end else begin
               state_in = S_PD_PARENT;
            end
         end
         S_LEAF_RD:   state_in = S_RET;
         S_EXACT_RD:  state_in = S_RET;
         S_PD_PARENT: state_in = S_PD_LEFT;
         S_PD_LEFT:   state_in = S_PD_RIGHT;
         S_PD_RIGHT:  state_in = S_PD_CLEAR;
         S_PD_CLEAR:  state_in = S_CHILD;
         S_CHILD: begin
            priority if (status.phase == 2'd0) begin
               state_in = (!is_query || status.has_left) ? S_ENTER : S_CHILD;
            end else if (status.phase == 2'd1) begin
               state_in = (!is_query || status.has_right) ? S_ENTER : S_CHILD;
            end else begin
               state_in = is_query ? S_RET : S_RC_LEFT;
            end
         end
         S_RC_LEFT:  state_in = S_RC_RIGHT;
         S_RC_RIGHT: state_in = S_RET;
         S_RET: begin
            priority if (!status.sp_zero) begin
               state_in = S_CHILD;
            end else if (is_query) begin
               state_in = S_RESP;
            end else begin
               state_in = S_IDLE;
            end
         end
         S_RESP: begin
            if (status.rsp_free) begin
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_comb begin
      cmd          = '0;
      cmd.rd_sel   = RD_SELF;
      cmd.wr_sel   = WR_NONE;
      cmd.frame_op = FR_NONE;
      cmd.ret_sel  = RET_NONE;
      req_stall    = state_ff != S_IDLE;
      unique case (state_ff)
         S_IDLE: begin
            cmd.take = req_valid;
         end
         S_LEAF_RD: begin
            cmd.wr_sel = WR_LEAF;
         end
         S_EXACT_RD: begin
            if (is_query) begin
               cmd.ret_sel = RET_EXACT;
            end else begin
               cmd.wr_sel = WR_EXACT_ADD;
            end
         end
         S_PD_PARENT: begin
            cmd.pd_latch = 1'b1;
            cmd.rd_sel   = RD_LEFT;
         end
         S_PD_LEFT: begin
            cmd.wr_sel = WR_PD_LEFT;
            cmd.rd_sel = RD_RIGHT;
         end
         S_PD_RIGHT: begin
            cmd.wr_sel = WR_PD_RIGHT;
         end
         S_PD_CLEAR: begin
            cmd.wr_sel = WR_PD_CLEAR;
         end
         S_CHILD: begin
            priority if (status.phase == 2'd0) begin
               cmd.frame_op = (!is_query || status.has_left) ? FR_PUSH_LEFT : FR_ADV;
            end else if (status.phase == 2'd1) begin
               cmd.frame_op = (!is_query || status.has_right) ? FR_PUSH_RIGHT : FR_ADV;
            end else if (is_query) begin
               cmd.ret_sel = RET_ACC;
            end else begin
               cmd.rd_sel = RD_LEFT;
            end
         end
         S_RC_LEFT: begin
            cmd.rc_latch = 1'b1;
            cmd.rd_sel   = RD_RIGHT;
         end
         S_RC_RIGHT: begin
            cmd.wr_sel = WR_RECOMBINE;
         end
         S_RET: begin
            if (!status.sp_zero) begin
               cmd.frame_op = FR_POP;
            end
         end
         S_RESP: begin
            cmd.rsp_load = status.rsp_free;
         end
         default: begin
            cmd.take = 1'b0;
         end
      endcase
   end

endmodule

// File: design/lazy_range_add_min_tree.sv
// Top level: lazy segment tree with range add and range minimum over 48-bit values.
//
// Usage:
//  - req_* carries one item: mode 0 loads req_value at req_index_low, mode 1
//    builds the tree over the first n_used elements, mode 2 adds req_value to
//    every element in [req_index_low, req_index_high], mode 3 returns the
//    minimum over that range on rsp_*. Only mode 3 gives a result item.
//  - csr_* writes n_used (0 acts as 1, above 1024 acts as 1024); csr_ready is
//    always high. Write it only while the block is idle, then rebuild.
//  - Items are taken one at a time; req_stall is high while a walk runs.
//    A load starts no walk; an add or query walk touches up to four nodes
//    per level of the tree.
//  - Results sit in an output register; the next item is accepted while a
//    result still waits. A finished query holds in the walk until rsp is free.
//  - Reset clears control state. The node memories get no clearing pass:
//    issue a build before any add or query.
module lazy_range_add_min_tree import lramt_pkg::*; (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     csr_valid,
   output logic                     csr_ready,
   input  logic [N_W-1:0]           csr_n_used,
   input  logic                     req_valid,
   output logic                     req_stall,
   input  logic [1:0]               req_mode,
   input  logic [IDX_W-1:0]         req_index_low,
   input  logic [IDX_W-1:0]         req_index_high,
   input  logic signed [DATA_W-1:0] req_value,
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output logic signed [DATA_W-1:0] rsp_min_value,
   output logic                     rsp_empty_range
);

   cmd_type    cmd;
   status_type status;

   // Take register writes at any time.
   assign csr_ready = 1'b1;

   lramt_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_mode  (req_mode),
      .status    (status),
      .req_stall (req_stall),
      .cmd       (cmd)
   );

   lramt_dp u_dp (
      .clock           (clock),
      .reset           (reset),
      .csr_write       (csr_valid && csr_ready),
      .csr_n_used      (csr_n_used),
      .req_mode        (req_mode),
      .req_index_low   (req_index_low),
      .req_index_high  (req_index_high),
      .req_value       (req_value),
      .rsp_stall       (rsp_stall),
      .cmd             (cmd),
      .status          (status),
      .rsp_valid       (rsp_valid),
      .rsp_min_value   (rsp_min_value),
      .rsp_empty_range (rsp_empty_range)
   );

   // Load the output register only when its slot frees this edge.
   a_rsp_load_free: assert property (@(posedge clock) disable iff (reset)
      cmd.rsp_load |-> status.rsp_free)
      else $error("result loaded over a waiting result");

   // Pop only with a saved parent on the stack.
   a_pop_has_parent: assert property (@(posedge clock) disable iff (reset)
      cmd.frame_op == FR_POP |-> !status.sp_zero)
      else $error("walk stack underflow");

   // Write leaves from the element store only during a build.
   a_leaf_in_build: assert property (@(posedge clock) disable iff (reset)
      cmd.wr_sel == WR_LEAF |-> (status.op == MODE_BUILD && status.leaf))
      else $error("leaf write outside build");

   // Accept no item while a walk holds the block.
   a_take_idle: assert property (@(posedge clock) disable iff (reset)
      cmd.take |=> (cmd.take == 1'b0 || $past(req_mode) == MODE_LOAD))
      else $error("item taken during a walk");

endmodule

// File: tb/lazy_range_add_min_tree_test.sv
// Self-checking testbench for the lazy range-add / range-min tree.
module lazy_range_add_min_tree_test;
   import lramt_pkg::*;

   localparam int CYCLE_LIMIT = 4000000;

   logic                     clock;
   logic                     reset;
   logic                     csr_valid;
   logic                     csr_ready;
   logic [N_W-1:0]           csr_n_used;
   logic                     req_valid;
   logic                     req_stall;
   logic [1:0]               req_mode;
   logic [IDX_W-1:0]         req_index_low;
   logic [IDX_W-1:0]         req_index_high;
   logic signed [DATA_W-1:0] req_value;
   logic                     rsp_valid;
   logic                     rsp_stall = 1'b0;
   logic signed [DATA_W-1:0] rsp_min_value;
   logic                     rsp_empty_range;

   lazy_range_add_min_tree dut (
      .clock(clock), .reset(reset),
      .csr_valid(csr_valid), .csr_ready(csr_ready), .csr_n_used(csr_n_used),
      .req_valid(req_valid), .req_stall(req_stall), .req_mode(req_mode),
      .req_index_low(req_index_low), .req_index_high(req_index_high),
      .req_value(req_value),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
      .rsp_min_value(rsp_min_value), .rsp_empty_range(rsp_empty_range)
   );

   typedef struct {
      logic [DATA_W-1:0] min_value;
      logic              empty_range;
   } min_result_type;

   // Shadow copy of the tree, its tags, the element store and the register.
   logic [DATA_W-1:0] shadow_node[TREE_NODES];
   logic [DATA_W-1:0] shadow_tag[TREE_NODES];
   logic [DATA_W-1:0] shadow_elem[MAX_ELEMENTS];
   int unsigned       shadow_n_used;

   min_result_type pending_mins[$];
   int  error_count = 0;
   int  cycle_count = 0;
   int  send_idle_pct;
   int  recv_idle_pct;
   event holdoff_start;
   bit  holdoff_active = 1'b0;

   // ------------------------------------------------------------------
   // Predictor
   // ------------------------------------------------------------------
   function automatic logic [DATA_W-1:0] smaller48(logic [DATA_W-1:0] a,
                                                   logic [DATA_W-1:0] b);
      return ($signed(a) <= $signed(b)) ? a : b;
   endfunction

   function automatic logic [DATA_W-1:0] node_read(int unsigned v);
      return (v < TREE_NODES) ? shadow_node[v] : '0;
   endfunction

   function automatic void node_bump(int unsigned v, logic [DATA_W-1:0] a);
      if (v < TREE_NODES) begin
         shadow_node[v] = shadow_node[v] + a;
         shadow_tag[v]  = shadow_tag[v] + a;
      end
   endfunction

   function automatic void push_tag(int unsigned v);
      if (v < TREE_NODES) begin
         node_bump(2 * v, shadow_tag[v]);
         node_bump(2 * v + 1, shadow_tag[v]);
         shadow_tag[v] = '0;
      end
   endfunction

   function automatic void refresh_node(int unsigned v);
      if (v < TREE_NODES) shadow_node[v] = smaller48(node_read(2 * v), node_read(2 * v + 1));
   endfunction

   function automatic void build_span(int unsigned v, int unsigned tl, int unsigned tr);
      int unsigned tm;
      if (v >= TREE_NODES) return;
      if (tl == tr) begin
         shadow_node[v] = (tl < MAX_ELEMENTS) ? shadow_elem[tl] : '0;
         return;
      end
      tm = (tl + tr) / 2;
      build_span(2 * v, tl, tm);
      build_span(2 * v + 1, tm + 1, tr);
      refresh_node(v);
   endfunction

   function automatic void add_span(int unsigned v, int unsigned tl, int unsigned tr,
                                    int unsigned l, int unsigned r, logic [DATA_W-1:0] a);
      int unsigned tm;
      if (l > r) return;
      if (l == tl && r == tr) begin
         node_bump(v, a);
         return;
      end
      push_tag(v);
      tm = (tl + tr) / 2;
      add_span(2 * v, tl, tm, l, (r < tm) ? r : tm, a);
      add_span(2 * v + 1, tm + 1, tr, (l > tm + 1) ? l : tm + 1, r, a);
      refresh_node(v);
   endfunction

   function automatic logic [DATA_W-1:0] min_span(int unsigned v, int unsigned tl,
                                                  int unsigned tr, int unsigned l,
                                                  int unsigned r);
      int unsigned       tm;
      bit                go_left, go_right;
      logic [DATA_W-1:0] lo, hi;
      lo = '0;
      hi = '0;
      if (l == tl && r == tr) return node_read(v);
      push_tag(v);
      tm = (tl + tr) / 2;
      go_left  = (l <= tm);
      go_right = (r >= tm + 1);
      if (go_left) lo = min_span(2 * v, tl, tm, l, (r < tm) ? r : tm);
      if (go_right) hi = min_span(2 * v + 1, tm + 1, tr, (l > tm + 1) ? l : tm + 1, r);
      if (go_left && go_right) return smaller48(lo, hi);
      return go_left ? lo : hi;
   endfunction

   function automatic int unsigned span_size();
      if (shadow_n_used == 0) return 1;
      if (shadow_n_used > MAX_ELEMENTS) return MAX_ELEMENTS;
      return shadow_n_used;
   endfunction

   // Apply one accepted item to the shadow tree; queue the query result.
   function automatic void predict_item(mode_type m, int unsigned l, int unsigned r,
                                        logic [DATA_W-1:0] val);
      int unsigned    n;
      min_result_type res;
      n = span_size();
      case (m)
         MODE_LOAD: shadow_elem[l] = val;
         MODE_BUILD: begin
            for (int i = 0; i < TREE_NODES; i++) shadow_tag[i] = '0;
            build_span(1, 0, n - 1);
         end
         default: begin
            if (r > n - 1) r = n - 1;
            if (m == MODE_ADD) begin
               add_span(1, 0, n - 1, l, r, val);
            end else if (l > r) begin
               res.min_value   = EMPTY_MARK;
               res.empty_range = 1'b1;
               pending_mins.insert(pending_mins.size(), res);
            end else begin
               res.min_value   = min_span(1, 0, n - 1, l, r);
               res.empty_range = 1'b0;
               pending_mins.insert(pending_mins.size(), res);
            end
         end
      endcase
   endfunction

   // ------------------------------------------------------------------
   // Clock, reset, timeout
   // ------------------------------------------------------------------
   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("[lazy_range_add_min_tree] ERROR");
         $finish;
      end
   end

   // ------------------------------------------------------------------
   // Result side: check against the oldest expectation, then pick stall
   // ------------------------------------------------------------------
   task automatic report_mismatch(string what, logic [DATA_W-1:0] got,
                                  logic [DATA_W-1:0] want);
      $display("mismatch %s: got %0d expected %0d", what, $signed(got), $signed(want));
      error_count++;
   endtask

   always @(posedge clock) begin
      min_result_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_mins.size() == 0) begin
            report_mismatch("unexpected result item", rsp_min_value, '0);
         end else begin
            want = pending_mins.pop_front();
            if (rsp_min_value !== want.min_value)
               report_mismatch("min_value", rsp_min_value, want.min_value);
            if (rsp_empty_range !== want.empty_range)
               report_mismatch("empty_range", DATA_W'(rsp_empty_range),
                               DATA_W'(want.empty_range));
         end
      end
      // Hold off for a long stretch when asked, else stall at random.
      if (holdoff_active) begin
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= ($urandom_range(99) < recv_idle_pct);
      end
   end

   // Count out a long result-side hold-off each time a test asks for one.
   initial begin
      forever begin
         @(holdoff_start);
         holdoff_active <= 1'b1;
         repeat (3000) @(posedge clock);
         holdoff_active <= 1'b0;
      end
   end

   // ------------------------------------------------------------------
   // Shared helpers
   // ------------------------------------------------------------------
   // Offer one item, wait for acceptance, predict, then maybe idle.
   task automatic send_item(mode_type m, int unsigned l, int unsigned r,
                            logic [DATA_W-1:0] val);
      int gap;
      req_valid      <= 1'b1;
      req_mode       <= m;
      req_index_low  <= IDX_W'(l);
      req_index_high <= IDX_W'(r);
      req_value      <= val;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      predict_item(m, l, r, val);
      if ($urandom_range(99) < send_idle_pct) begin
         gap = $urandom_range(1, 6);
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic wait_drained();
      while (pending_mins.size() != 0) @(posedge clock);
   endtask

   // Write n_used once the block is idle; the tree must be rebuilt after.
   task automatic write_n_used(logic [N_W-1:0] n);
      req_valid <= 1'b0;
      wait_drained();
      repeat (20) @(posedge clock);
      csr_valid  <= 1'b1;
      csr_n_used <= n;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid     <= 1'b0;
      shadow_n_used = n;
   endtask

   function automatic logic [DATA_W-1:0] random_value();
      case ($urandom_range(3))
         0: return DATA_W'({$urandom, $urandom});
         1: return DATA_W'($signed($urandom_range(2000)) - 1000);
         2: return {{16{1'b0}}, $urandom};
         default: return {{16{1'b1}}, $urandom};
      endcase
   endfunction

   function automatic int unsigned random_index(int unsigned n);
      return ($urandom_range(9) == 0) ? $urandom_range(LAST_INDEX) : $urandom_range(n - 1);
   endfunction

   // One random item; builds are rare since they walk the whole tree.
   task automatic send_random_item();
      int unsigned n, pick, l, r;
      n    = span_size();
      pick = $urandom_range(99);
      l    = random_index(n);
      r    = ($urandom_range(3) == 0) ? random_index(n) : l + $urandom_range(n - 1);
      if (r > LAST_INDEX) r = LAST_INDEX;
      if (pick < 14) send_item(MODE_LOAD, $urandom_range(LAST_INDEX), r, random_value());
      else if (pick < 16) send_item(MODE_BUILD, l, r, random_value());
      else if (pick < 52) send_item(MODE_ADD, l, r, random_value());
      else send_item(MODE_QUERY, l, r, random_value());
   endtask

   // ------------------------------------------------------------------
   // Tests
   // ------------------------------------------------------------------
   // Small tree, value extremes, wrap, empty and clipped ranges.
   task automatic test_directed();
      logic [DATA_W-1:0] most_pos, most_neg;
      most_pos = {1'b0, {(DATA_W-1){1'b1}}};
      most_neg = {1'b1, {(DATA_W-1){1'b0}}};
      write_n_used(11'd8);
      send_item(MODE_LOAD, 0, 0, most_pos);
      send_item(MODE_LOAD, 1, 1, most_neg);
      send_item(MODE_LOAD, 2, 2, '0);
      send_item(MODE_LOAD, 3, 3, '1);
      for (int i = 4; i < 8; i++) send_item(MODE_LOAD, i, i, DATA_W'(100 * i));
      send_item(MODE_LOAD, LAST_INDEX, 0, most_neg);
      send_item(MODE_BUILD, 0, 0, '0);
      send_item(MODE_QUERY, 0, 7, '0);
      send_item(MODE_QUERY, 0, LAST_INDEX, '0);
      send_item(MODE_QUERY, 5, 2, '0);
      send_item(MODE_QUERY, LAST_INDEX, LAST_INDEX, '0);
      // Wrap the most negative element around to the top.
      send_item(MODE_ADD, 1, 1, '1);
      send_item(MODE_QUERY, 0, 3, '0);
      send_item(MODE_ADD, 0, 0, 48'd1);
      send_item(MODE_QUERY, 0, 1, '0);
      send_item(MODE_ADD, 2, LAST_INDEX, most_neg);
      send_item(MODE_ADD, 6, 3, most_pos);
      send_item(MODE_ADD, 9, LAST_INDEX, most_pos);
      send_item(MODE_QUERY, 3, 6, '0);
      send_item(MODE_QUERY, 7, 7, '0);
      // Rebuild drops pending tags.
      send_item(MODE_BUILD, 0, 0, '0);
      send_item(MODE_QUERY, 0, 7, '0);
   endtask

   // Fill the whole store so any later size can build over loaded elements.
   task automatic test_full_store();
      write_n_used(11'h7FF);
      for (int i = 0; i < MAX_ELEMENTS; i++) send_item(MODE_LOAD, i, i, random_value());
      send_item(MODE_BUILD, 0, 0, '0);
      repeat (10) send_random_item();
      send_item(MODE_QUERY, 0, LAST_INDEX, '0);
   endtask

   // Random traffic at a given size; close with a query so idle is visible.
   task automatic test_random_size(logic [N_W-1:0] n, int count);
      write_n_used(n);
      send_item(MODE_BUILD, 0, 0, '0);
      repeat (count) send_random_item();
      send_item(MODE_QUERY, 0, LAST_INDEX, '0);
   endtask

   // Stall the result side long enough to fill the block, then drain.
   task automatic test_backpressure();
      -> holdoff_start;
      repeat (20) send_item(MODE_QUERY, random_index(span_size()), LAST_INDEX, '0);
      req_valid <= 1'b0;
      wait_drained();
      repeat (6) send_random_item();
      send_item(MODE_QUERY, 0, LAST_INDEX, '0);
   endtask

   initial begin
      reset          = 1'b1;
      csr_valid      = 1'b0;
      csr_n_used     = '0;
      req_valid      = 1'b0;
      req_mode       = MODE_LOAD;
      req_index_low  = '0;
      req_index_high = '0;
      req_value      = '0;
      send_idle_pct  = 0;
      recv_idle_pct  = 0;
      shadow_n_used  = N_RESET;
      for (int i = 0; i < TREE_NODES; i++) begin
         shadow_node[i] = '0;
         shadow_tag[i]  = '0;
      end
      for (int i = 0; i < MAX_ELEMENTS; i++) shadow_elem[i] = '0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_directed();
      test_full_store();
      test_random_size(11'd1, 4);
      send_idle_pct = 61;
      test_random_size(11'd0, 4);
      test_random_size(11'd2, 6);
      send_idle_pct = 0;
      recv_idle_pct = 61;
      test_random_size(11'd37, 10);
      test_random_size(11'd1024, 8);
      send_idle_pct = 36;
      recv_idle_pct = 36;
      test_random_size(N_W'($urandom_range(3, 300)), 10);
      test_random_size(11'd1500, 6);
      send_idle_pct = 0;
      recv_idle_pct = 0;
      test_backpressure();

      // Drain, then give the last walk time to settle.
      req_valid <= 1'b0;
      wait_drained();
      repeat (50) @(posedge clock);
      if (error_count == 0 && pending_mins.size() == 0) begin
         $display("[lazy_range_add_min_tree] OK");
      end else begin
         $display("[lazy_range_add_min_tree] ERROR");
      end
      $finish;
   end

endmodule
